>>> rtl/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg: shared types and constants for the log stream header stripper
// Window geometry, head decision codes, cell controls and marker bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package lsh_pkg;

  localparam int unsigned WIN_DEPTH = 8;
  localparam int unsigned LINES_W   = 17;

  localparam logic [7:0] BYTE_ZERO = 8'h30;  // ASCII '0'
  localparam logic [7:0] BYTE_CR   = 8'h0d;
  localparam logic [7:0] BYTE_LF   = 8'h0a;
  localparam logic [7:0] BYTE_OUT  = 8'h01;  // stdout stream id
  localparam logic [7:0] BYTE_ERR  = 8'h02;  // stderr stream id
  localparam logic [7:0] BYTE_NUL  = 8'h00;

  localparam logic [LINES_W-1:0] LINES_MAX = '1;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  typedef enum logic [1:0] {
    DEC_EMIT,
    DEC_STOP,
    DEC_DROP
  } dec_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/log_stream_header_strip_core.sv
// ----------------------------------------------------------------------------
// log_stream_header_strip_core: container log stream cleaner
// Strips 8-byte frame headers, stops on a '0' CR LF terminator or on the
// line limit, and flushes an 8-byte lookahead window on the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one raw byte per request, with
//   in_last on the final byte of a stream. Output channel (out_valid/
//   out_ready) carries kept bytes; out_end flags the last result of a stream
//   and out_has_byte=0 marks a bare end marker.
//   Throughput: one request per cycle for bytes not flagged last, while the
//   output register is free; a result, when one is due, appears in the output
//   register the cycle after the request. The window is a row of eight byte
//   cells that shift towards the head each time a byte is emitted.
//   Last byte: once the request is taken, the window drains one head decision
//   per cycle while the output register is free (up to 8 emits, then a
//   closing step); in_ready stays low meanwhile.
//   Stall: a result waits in the output register while out_ready is low;
//   a new request is taken in the same cycle the waiting result leaves.
//   Reset (rst, synchronous) empties the window, sets the line count to one,
//   clears the stop flag and sets line_limit to zero (built-in default).
//   cfg_wr_en writes line_limit; write only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module log_stream_header_strip_core
  import lsh_pkg::*;
#(
  parameter int unsigned DEFAULT_LINE_LIMIT = 1000
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_has_byte,
  output logic             out_end
);

  localparam logic [15:0] DEF_LIMIT = 16'(DEFAULT_LINE_LIMIT);

  // control state
  logic [15:0]        line_limit;
  logic [3:0]         fill, fill_next;
  logic [LINES_W-1:0] lines, lines_next;
  logic               stopped, stopped_next;
  logic               flushing, flushing_next;
  logic               pend_valid, pend_valid_next;
  logic [7:0]         pend_byte, pend_byte_next;
  logic               out_valid_next;
  logic [7:0]         out_byte_next;
  logic               out_has_byte_next, out_end_next;

  logic       out_free;
  logic       in_acc;
  logic       flush_step;
  logic       append;
  logic       shift;
  logic [3:0] load_idx;
  logic [3:0] head_fill;
  logic [15:0] eff_limit;
  dec_t       dec;
  win_t       win;

  assign out_free   = !out_valid || out_ready;
  assign in_ready   = !flushing && out_free;
  assign in_acc     = in_valid && in_ready;
  assign flush_step = flushing && out_free;
  assign eff_limit  = (line_limit == 16'd0) ? DEF_LIMIT : line_limit;
  // outside the flush a decision is only taken once the window is full
  assign head_fill  = flushing ? fill : 4'(WIN_DEPTH);
  assign load_idx   = shift ? (fill - 4'd1) : fill;

  // --------------------------------------------------------------------------
  // Window cells: cell 0 is the head
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic [7:0] nbr;

    assign ctrl.load  = append && (load_idx == 4'(i));
    assign ctrl.shift = shift;

    if (i == WIN_DEPTH - 1) begin : g_tail
      assign nbr = BYTE_NUL;
    end else begin : g_body
      assign nbr = win[i+1];
    end

    lsh_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .byte_in (in_byte),
      .nbr     (nbr),
      .data    (win[i])
    );
  end

  lsh_head u_head (
    .win   (win),
    .fill  (head_fill),
    .lines (lines),
    .limit (eff_limit),
    .dec   (dec)
  );

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    fill_next         = fill;
    lines_next        = lines;
    stopped_next      = stopped;
    flushing_next     = flushing;
    pend_valid_next   = pend_valid;
    pend_byte_next    = pend_byte;
    out_valid_next    = out_valid && !out_ready;
    out_byte_next     = out_byte;
    out_has_byte_next = out_has_byte;
    out_end_next      = out_end;
    append            = 1'b0;
    shift             = 1'b0;

    if (in_acc) begin
      // drop incoming bytes once the stream has stopped
      append = !stopped && (fill < 4'(WIN_DEPTH));
      if (in_last) begin
        flushing_next   = 1'b1;
        pend_valid_next = 1'b0;
        if (append) begin
          fill_next = fill + 4'd1;
        end
      end else if (!stopped) begin
        if (fill == 4'(WIN_DEPTH - 1)) begin
          unique case (dec)
            DEC_EMIT: begin
              shift             = 1'b1;
              out_valid_next    = 1'b1;
              out_byte_next     = win[0];
              out_has_byte_next = 1'b1;
              out_end_next      = 1'b0;
              if (win[0] == BYTE_LF && lines != LINES_MAX) begin
                lines_next = lines + 1'b1;
              end
            end
            DEC_STOP: begin
              stopped_next = 1'b1;
              fill_next    = 4'd0;
            end
            DEC_DROP: begin
              fill_next = 4'd0;
            end
            default: begin
              fill_next = fill;
            end
          endcase
        end else begin
          fill_next = fill + 4'd1;
        end
      end
    end else if (flush_step) begin
      if (stopped || fill == 4'd0) begin
        // close the stream: release the held byte as final, or a bare marker
        out_valid_next    = 1'b1;
        out_byte_next     = pend_valid ? pend_byte : BYTE_NUL;
        out_has_byte_next = pend_valid;
        out_end_next      = 1'b1;
        flushing_next     = 1'b0;
        pend_valid_next   = 1'b0;
        fill_next         = 4'd0;
        lines_next        = LINES_W'(1);
        stopped_next      = 1'b0;
      end else begin
        unique case (dec)
          DEC_EMIT: begin
            // hold the latest emitted byte back until it is known whether it is final
            shift           = 1'b1;
            fill_next       = fill - 4'd1;
            pend_valid_next = 1'b1;
            pend_byte_next  = win[0];
            if (win[0] == BYTE_LF && lines != LINES_MAX) begin
              lines_next = lines + 1'b1;
            end
            if (pend_valid) begin
              out_valid_next    = 1'b1;
              out_byte_next     = pend_byte;
              out_has_byte_next = 1'b1;
              out_end_next      = 1'b0;
            end
          end
          DEC_STOP: begin
            stopped_next = 1'b1;
            fill_next    = 4'd0;
          end
          DEC_DROP: begin
            fill_next = 4'd0;
          end
          default: begin
            fill_next = fill;
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= 16'd0;
      fill       <= 4'd0;
      lines      <= LINES_W'(1);
      stopped    <= 1'b0;
      flushing   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        line_limit <= cfg_wr_data;
      end
      fill       <= fill_next;
      lines      <= lines_next;
      stopped    <= stopped_next;
      flushing   <= flushing_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_byte    <= pend_byte_next;
    out_byte     <= out_byte_next;
    out_has_byte <= out_has_byte_next;
    out_end      <= out_end_next;
  end

endmodule

`default_nettype wire

>>> rtl/lsh_cell.sv
// ----------------------------------------------------------------------------
// lsh_cell: one byte slot of the lookahead window
// Load a new byte, take the neighbour's byte on a shift, or hold.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_cell
  import lsh_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic [7:0] byte_in,
  input  wire logic [7:0] nbr,
  output logic      [7:0] data
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= byte_in;
    end else if (ctrl.shift) begin
      data <= nbr;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lsh_head.sv
// ----------------------------------------------------------------------------
// lsh_head: decision at the head of the window
// Terminator, line limit and frame header tests, in priority order.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_head
  import lsh_pkg::*;
(
  input  wire win_t               win,
  input  wire logic [3:0]         fill,
  input  wire logic [LINES_W-1:0] lines,
  input  wire logic [15:0]        limit,
  output dec_t                    dec
);

  logic term_hit;
  logic hdr_hit;

  assign term_hit = (fill >= 4'd3) && (win[0] == BYTE_ZERO) &&
                    (win[1] == BYTE_CR) && (win[2] == BYTE_LF);

  assign hdr_hit = (fill >= 4'(WIN_DEPTH)) &&
                   ((win[0] == BYTE_OUT) || (win[0] == BYTE_ERR)) &&
                   (win[1] == BYTE_NUL) && (win[2] == BYTE_NUL) &&
                   (win[3] == BYTE_NUL) && (win[4] == BYTE_NUL) &&
                   (win[5] == BYTE_NUL);

  always_comb begin
    if (term_hit) begin
      dec = DEC_STOP;
    end else if (lines > {1'b0, limit}) begin
      dec = DEC_STOP;
    end else if (hdr_hit) begin
      dec = DEC_DROP;
    end else begin
      dec = DEC_EMIT;
    end
  end

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for log_stream_header_strip_core
// Streams of raw log bytes with frame headers, '0' CR LF terminators, line
// breaks and noise are pushed through the core under several line limits and
// handshake idling mixes. An in-bench predictor works out the kept bytes of
// each request, and every result leaving the core is compared in order.
// ----------------------------------------------------------------------------
module tb_top
  import lsh_pkg::*;
();

  localparam int DEFAULT_LIMIT = 1000;
  localparam int HOLD_CYCLES   = 80;    // long receiver hold-off
  localparam int DRAIN_CYCLES  = 16;    // wait for a last-byte drain to finish
  localparam int WATCHDOG      = 3000;  // cycles with no request or result moving
  localparam int PHASE_ITEMS   = 45;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       fin;
  } kept_t;

  typedef enum int {CH_TEXT, CH_HEADER, CH_TERM, CH_BROKEN, CH_LF, CH_NOISE} chunk_t;

  // Tracks the window, line count and stop flag of the core, and holds the
  // results that are still owed by it, oldest first.
  class kept_byte_board;
    logic [7:0]  win [WIN_DEPTH];
    int unsigned fill;
    logic [16:0] lines;
    bit          stopped;
    logic [15:0] limit;
    kept_t       kept_q[$];
    int          errors;
    int          taken;

    function new();
      limit  = '0;
      errors = 0;
      taken  = 0;
      restart();
    endfunction

    function void restart();
      fill    = 0;
      lines   = 17'd1;
      stopped = 1'b0;
    endfunction

    function int pending();
      return kept_q.size();
    endfunction

    // One decision at the head of the window; a kept byte joins kept_q.
    function dec_t decide_head();
      logic [16:0] cap;
      cap = (limit == '0) ? 17'(DEFAULT_LIMIT) : {1'b0, limit};
      if (fill >= 3 && win[0] == BYTE_ZERO && win[1] == BYTE_CR && win[2] == BYTE_LF) begin
        stopped = 1'b1;
        fill    = 0;
        return DEC_STOP;
      end
      if (lines > cap) begin
        stopped = 1'b1;
        fill    = 0;
        return DEC_STOP;
      end
      if (fill == WIN_DEPTH && (win[0] == BYTE_OUT || win[0] == BYTE_ERR) &&
          win[1] == BYTE_NUL && win[2] == BYTE_NUL && win[3] == BYTE_NUL &&
          win[4] == BYTE_NUL && win[5] == BYTE_NUL) begin
        fill = 0;
        return DEC_DROP;
      end
      kept_q.insert(kept_q.size(), kept_t'{data: win[0], has_byte: 1'b1, fin: 1'b0});
      if (win[0] == BYTE_LF && lines != LINES_MAX) lines++;
      for (int i = 0; i < WIN_DEPTH - 1; i++) win[i] = win[i + 1];
      fill--;
      return DEC_EMIT;
    endfunction

    function void note_request(logic [7:0] b, logic last);
      int emitted;
      emitted = 0;
      taken++;
      if (!stopped && fill < WIN_DEPTH) begin
        win[fill] = b;
        fill++;
      end
      if (!last) begin
        if (!stopped && fill == WIN_DEPTH) void'(decide_head());
        return;
      end
      while (!stopped && fill > 0) begin
        if (decide_head() == DEC_EMIT) emitted++;
      end
      if (emitted > 0) kept_q[kept_q.size() - 1].fin = 1'b1;
      else kept_q.insert(kept_q.size(), kept_t'{data: 8'h00, has_byte: 1'b0, fin: 1'b1});
      restart();
    endfunction

    function void check_result(logic [7:0] data, logic has_byte, logic fin);
      kept_t want;
      if (kept_q.size() == 0) begin
        $display("%0t: unexpected result byte %02h has_byte %0b end %0b",
                 $time, data, has_byte, fin);
        errors++;
        return;
      end
      want = kept_q.pop_front();
      if (data !== want.data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
        errors++;
      end
      if (has_byte !== want.has_byte) begin
        $display("%0t: out_has_byte expected %0b actual %0b", $time, want.has_byte, has_byte);
        errors++;
      end
      if (fin !== want.fin) begin
        $display("%0t: out_end expected %0b actual %0b", $time, want.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst          = 1'b1;
  logic        cfg_wr_en    = 1'b0;
  logic [15:0] cfg_wr_data  = '0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte      = '0;
  logic        in_last      = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [7:0]  out_byte;
  logic        out_has_byte;
  logic        out_end;

  int idle_pct  = 0;   // sender idles this many cycles in a hundred
  int stall_pct = 0;   // receiver stalls this many cycles in a hundred
  bit hold_req  = 1'b0;

  kept_byte_board board = new();

  log_stream_header_strip_core #(
    .DEFAULT_LINE_LIMIT(DEFAULT_LIMIT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_has_byte(out_has_byte),
    .out_end     (out_end)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sample both channels mid-cycle: inputs only change on the rising edge, so
  // what stands here is what the next edge will take.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check_result(out_byte, out_has_byte, out_end);
      if (in_valid && in_ready) board.note_request(in_byte, in_last);
    end
  end

  // Receiver: random stalls, or one long hold-off on request so that the
  // output register stays full and the core stops taking requests.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Give up when neither channel has moved for a long while.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Offer one request and hold it until taken; entered and left on a rising edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
  endtask

  task automatic send_stream(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // Drop valid, wait for every owed result, then let a last-byte drain finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.limit = value;
  endtask

  // Build one stream out of text lines, frame headers, terminators, headers
  // spoilt after a few bytes, bare newlines and raw noise.
  function automatic void make_stream(ref logic [7:0] q[$]);
    int     chunks;
    int     len;
    int     pick;
    chunk_t kind;
    q.delete();
    if ($urandom_range(9) == 0) begin
      q.insert(q.size(), 8'($urandom));
      return;
    end
    chunks = $urandom_range(1, 5);
    repeat (chunks) begin
      pick = $urandom_range(11);
      if (pick < 4) kind = CH_TEXT;
      else if (pick < 7) kind = CH_HEADER;
      else if (pick == 7) kind = CH_TERM;
      else if (pick == 8) kind = CH_BROKEN;
      else if (pick == 9) kind = CH_LF;
      else kind = CH_NOISE;
      case (kind)
        CH_TEXT: begin
          len = $urandom_range(1, 6);
          repeat (len) q.insert(q.size(), 8'($urandom_range(8'h20, 8'h7e)));
          if ($urandom_range(9) < 7) q.insert(q.size(), BYTE_LF);
        end
        CH_HEADER: begin
          q.insert(q.size(), $urandom_range(1) ? BYTE_ERR : BYTE_OUT);
          repeat (5) q.insert(q.size(), BYTE_NUL);
          q.insert(q.size(), 8'($urandom));
          q.insert(q.size(), 8'($urandom));
        end
        CH_TERM: begin
          q.insert(q.size(), BYTE_ZERO);
          q.insert(q.size(), BYTE_CR);
          q.insert(q.size(), BYTE_LF);
        end
        CH_BROKEN: begin
          q.insert(q.size(), $urandom_range(1) ? BYTE_ERR : BYTE_OUT);
          len = $urandom_range(0, 4);
          repeat (len) q.insert(q.size(), BYTE_NUL);
          q.insert(q.size(), 8'($urandom_range(1, 255)));
        end
        CH_LF: q.insert(q.size(), BYTE_LF);
        default: begin
          len = $urandom_range(1, 4);
          repeat (len) q.insert(q.size(), 8'($urandom));
        end
      endcase
    end
  endfunction

  initial begin
    logic [7:0]  q[$];
    logic [15:0] limits [6];
    int          goal;

    limits = '{16'hFFFF, 16'd1, 16'd3, 16'd0,
               16'($urandom_range(2, 8)), 16'($urandom_range(65535))};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_limit(16'd0);

    // Directed: a stderr frame header dropped whole, then a newline flushed.
    q = {BYTE_ERR, BYTE_NUL, BYTE_NUL, BYTE_NUL, BYTE_NUL, BYTE_NUL, 8'hee, 8'h01, BYTE_LF};
    send_stream(q);
    // Terminator at the head stops the stream; bytes after it are dropped
    // and the last one brings a bare end marker.
    q = {BYTE_ZERO, BYTE_CR, BYTE_LF, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77};
    send_stream(q);
    // Single-byte stream at the top of the byte range.
    q = {8'hff};
    send_stream(q);
    // Header lookalike shorter than a window: every byte kept in the flush.
    q = {BYTE_OUT, BYTE_NUL, BYTE_NUL, BYTE_NUL, BYTE_NUL, BYTE_NUL};
    send_stream(q);

    // Random phases: one line limit each, idling mix advancing in turn.
    for (int p = 0; p < 6; p++) begin
      settle();
      write_limit(limits[p]);
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 52;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 52;
        end
        default: begin
          idle_pct  = 37;
          stall_pct = 37;
        end
      endcase
      if (p == 0) hold_req = 1'b1;
      goal = board.taken + PHASE_ITEMS;
      while (board.taken < goal) begin
        make_stream(q);
        send_stream(q);
      end
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
